// ===== sv/script_byte_lexer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the script byte lexer
// Shared same-cycle and next-cycle implication property forms.
// ---------------------------------------------------------------------------
`ifndef SCRIPT_BYTE_LEXER_ASSERT_SVH
`define SCRIPT_BYTE_LEXER_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define SBL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sbl_pkg.sv =====
// ---------------------------------------------------------------------------
// sbl_pkg
// Types, codes and the punctuator table of the script byte lexer.
// ---------------------------------------------------------------------------
package sbl_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int FIXED_RES_BITS    = 14;   // kind (6) + text value (8)
    localparam int SLOTS             = 4;    // words per bundle
    localparam int CNT_BITS          = 3;
    localparam int QUEUE_DEPTH       = 4;
    localparam int PUNCT_COUNT       = 51;

    localparam logic [5:0] KIND_IDENT  = 6'd51;
    localparam logic [5:0] KIND_NUMBER = 6'd52;
    localparam logic [5:0] KIND_STRING = 6'd53;
    localparam logic [5:0] KIND_END    = 6'd54;
    localparam logic [5:0] KIND_ERROR  = 6'd55;
    localparam logic [5:0] KIND_TEXT   = 6'd56;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [8:0] {
        MODE_NORMAL = 9'b000000001,
        MODE_IDENT  = 9'b000000010,
        MODE_INT    = 9'b000000100,
        MODE_FRAC   = 9'b000001000,
        MODE_STR    = 9'b000010000,
        MODE_ESC    = 9'b000100000,
        MODE_LINEC  = 9'b001000000,
        MODE_BLOCK  = 9'b010000000,
        MODE_STAR   = 9'b100000000
    } mode_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic       start;    // first byte begins some punctuator
        logic       prefix;   // window is a proper prefix of a longer one
        logic [2:0] len;      // longest match, at least 1
        logic [5:0] idx;
    } punct_res_t;

    // left-justified, first character in the top byte
    localparam logic [31:0] PUNCT_STR [PUNCT_COUNT] = '{
        {">>>="}, {">>>", 8'h00}, {"...", 8'h00}, {"<<=", 8'h00}, {">>=", 8'h00},
        {"**=", 8'h00}, {"===", 8'h00}, {"!==", 8'h00}, {">>", 16'h0}, {"<<", 16'h0},
        {"||", 16'h0}, {"&&", 16'h0}, {"++", 16'h0}, {"--", 16'h0}, {"==", 16'h0},
        {"**", 16'h0}, {"|=", 16'h0}, {"&=", 16'h0}, {"*=", 16'h0}, {"/=", 16'h0},
        {"%=", 16'h0}, {"+=", 16'h0}, {"-=", 16'h0}, {"^=", 16'h0}, {"!=", 16'h0},
        {">=", 16'h0}, {"<=", 16'h0}, {"=", 24'h0}, {",", 24'h0}, {"?", 24'h0},
        {":", 24'h0}, {"|", 24'h0}, {"^", 24'h0}, {"&", 24'h0}, {"~", 24'h0},
        {"!", 24'h0}, {";", 24'h0}, {"(", 24'h0}, {")", 24'h0}, {"{", 24'h0},
        {"}", 24'h0}, {"[", 24'h0}, {"]", 24'h0}, {">", 24'h0}, {"<", 24'h0},
        {"+", 24'h0}, {"-", 24'h0}, {"*", 24'h0}, {"/", 24'h0}, {"%", 24'h0},
        {".", 24'h0}
    };

    function automatic logic [31:0] head_mask(input logic [2:0] n);
        case (n)
            3'd0:    return 32'h0000_0000;
            3'd1:    return 32'hFF00_0000;
            3'd2:    return 32'hFFFF_0000;
            3'd3:    return 32'hFFFF_FF00;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [2:0] str_len(input logic [31:0] s);
        return 3'(s[31:24] != 8'h00) + 3'(s[23:16] != 8'h00)
             + 3'(s[15:8] != 8'h00) + 3'(s[7:0] != 8'h00);
    endfunction

    // match a window of rem bytes (first byte on top) against the table
    function automatic punct_res_t punct_match(input logic [31:0] win,
                                               input logic [2:0] rem);
        punct_res_t r;
        logic [2:0] best;
        logic [2:0] l;
        logic [31:0] s;
        r    = '0;
        best = 3'd0;
        for (int e = 0; e < PUNCT_COUNT; e++) begin
            s = PUNCT_STR[e];
            l = str_len(s);
            if (s[31:24] == win[31:24]) r.start = 1'b1;
            if (l > rem && ((s ^ win) & head_mask(rem)) == 32'h0) r.prefix = 1'b1;
            if (l <= rem && l > best && ((s ^ win) & head_mask(l)) == 32'h0) begin
                best  = l;
                r.idx = 6'(e);
            end
        end
        r.len = (best == 3'd0) ? 3'd1 : best;
        return r;
    endfunction

endpackage

// ===== sv/sbl_front.sv =====
// ---------------------------------------------------------------------------
// sbl_front
// Byte classifier: lexer state, punctuator walk, result bundle per byte.
// ---------------------------------------------------------------------------
module sbl_front #(
    parameter int POSITION_BITS = sbl_pkg::POSITION_BITS_DEF,
    localparam int RW = sbl_pkg::FIXED_RES_BITS + 3 * POSITION_BITS,
    localparam int BW = sbl_pkg::CNT_BITS + sbl_pkg::SLOTS * RW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  sbl_pkg::qstat_t      qstat,
    output logic                 push,
    output logic [BW-1:0]        push_data
);
    `include "script_byte_lexer_assert.svh"

    localparam int PB = POSITION_BITS;

    typedef struct packed {
        logic       start;
        logic       prefix;
        logic       cmt;
        logic       cmt_line;
        logic [2:0] rem;
        logic [2:0] len;
        logic [5:0] idx;
    } pos_t;

    sbl_pkg::mode_t  mode_reg, mode_next;
    logic [7:0]      held_reg [3];
    logic [7:0]      held_next [3];
    logic [1:0]      hc_reg, hc_next;
    logic [PB-1:0]   line_reg, line_next, col_reg, col_next;
    logic [PB-1:0]   sl_reg, sl_next, sc_reg, sc_next, tlen_reg, tlen_next;
    logic [7:0]      quote_reg, quote_next;
    logic            halted_reg, halted_next;

    logic            accept;
    logic [7:0]      x;
    logic            eos_eff;
    logic [7:0]      wb [4];
    logic [31:0]     wcat;
    logic [2:0]      m;
    pos_t            pinfo [4];
    logic [RW-1:0]   res [8];
    logic [3:0]      res_n;

    function automatic logic [PB-1:0] sat_add(input logic [PB-1:0] a,
                                              input logic [PB-1:0] b);
        logic [PB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PB] ? {PB{1'b1}} : s[PB-1:0];
    endfunction

    function automatic logic [RW-1:0] pack_res(input logic [5:0] kind,
                                               input logic [PB-1:0] ln,
                                               input logic [PB-1:0] col,
                                               input logic [PB-1:0] ec,
                                               input logic [7:0] tv);
        return {tv, ec, col, ln, kind};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || c == sbl_pkg::CH_DOLLAR || c == sbl_pkg::CH_UNDER;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == sbl_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            "n":     return 8'd10;
            "r":     return 8'd13;
            "t":     return 8'd9;
            "b":     return 8'd8;
            "f":     return 8'd12;
            "v":     return 8'd11;
            "0":     return 8'd0;
            default: return c;
        endcase
    endfunction

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign x        = s_tdata;
    assign eos_eff  = (x == 8'h00) || s_tlast;

    // walk window: held bytes, then the new byte
    always_comb begin : window
        sbl_pkg::punct_res_t r;
        logic [31:0] win;
        logic [2:0]  rem;
        for (int j = 0; j < 4; j++) begin
            if (j < 3 && 2'(j) < hc_reg) wb[j] = held_reg[j];
            else if (3'(j) == {1'b0, hc_reg} && x != 8'h00) wb[j] = x;
            else wb[j] = 8'h00;
        end
        wcat = {wb[0], wb[1], wb[2], wb[3]};
        m    = {1'b0, hc_reg} + 3'(x != 8'h00);
        for (int p = 0; p < 4; p++) begin
            rem = (3'(p) < m) ? m - 3'(p) : 3'd0;
            win = wcat << (8 * p);
            r   = sbl_pkg::punct_match(win, rem);
            pinfo[p].start    = r.start;
            pinfo[p].prefix   = r.prefix;
            pinfo[p].len      = r.len;
            pinfo[p].idx      = r.idx;
            pinfo[p].rem      = rem;
            pinfo[p].cmt      = win[31:24] == sbl_pkg::CH_SLASH && rem >= 3'd2
                             && (win[23:16] == sbl_pkg::CH_SLASH
                                 || win[23:16] == sbl_pkg::CH_STAR);
            pinfo[p].cmt_line = win[23:16] == sbl_pkg::CH_SLASH;
        end
    end

    always_comb begin : lex
        logic [PB-1:0] cc, cci, col0, bc;
        logic [3:0]    rn;
        logic [2:0]    i;
        logic          go;
        logic          walk_run;
        logic [31:0]   tmp;
        logic [7:0]    c;

        mode_next   = mode_reg;
        held_next   = held_reg;
        hc_next     = hc_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        sl_next     = sl_reg;
        sc_next     = sc_reg;
        tlen_next   = tlen_reg;
        quote_next  = quote_reg;
        halted_next = halted_reg;
        for (int s = 0; s < 8; s++) res[s] = '0;
        rn       = 4'd0;
        walk_run = 1'b0;
        i        = 3'd0;
        go       = 1'b1;
        tmp      = 32'h0;
        c        = 8'h00;
        cci      = '0;
        cc       = sat_add(col_reg, PB'(1));
        bc       = cc;
        col0     = (hc_reg != 2'd0) ? sc_reg : cc;

        if (!halted_reg) begin
            if (x != 8'h00) begin
                case (mode_reg)
                    sbl_pkg::MODE_IDENT: begin
                        if (is_id_start(x) || is_digit(x)) begin
                            tlen_next = sat_add(tlen_reg, PB'(1));
                            res[rn[2:0]] = pack_res(sbl_pkg::KIND_TEXT, line_reg, cc,
                                                    sat_add(cc, PB'(1)), x);
                            rn = rn + 4'd1;
                        end else begin
                            res[rn[2:0]] = pack_res(sbl_pkg::KIND_IDENT, sl_reg, sc_reg,
                                                    sat_add(sc_reg, tlen_reg), 8'h00);
                            rn = rn + 4'd1;
                            mode_next = sbl_pkg::MODE_NORMAL;
                            walk_run  = 1'b1;
                        end
                    end
                    sbl_pkg::MODE_INT, sbl_pkg::MODE_FRAC: begin
                        if (is_digit(x)) begin
                            tlen_next = sat_add(tlen_reg, PB'(1));
                        end else if (x == sbl_pkg::CH_DOT
                                     && mode_reg == sbl_pkg::MODE_INT) begin
                            tlen_next = sat_add(tlen_reg, PB'(1));
                            mode_next = sbl_pkg::MODE_FRAC;
                        end else begin
                            res[rn[2:0]] = pack_res(sbl_pkg::KIND_NUMBER, sl_reg, sc_reg,
                                sat_add(sc_reg, (tlen_reg != '0) ? tlen_reg - PB'(1) : '0),
                                8'h00);
                            rn = rn + 4'd1;
                            mode_next = sbl_pkg::MODE_NORMAL;
                            walk_run  = 1'b1;
                        end
                    end
                    sbl_pkg::MODE_STR: begin
                        if (x == quote_reg) begin
                            res[rn[2:0]] = pack_res(sbl_pkg::KIND_STRING, sl_reg, sc_reg,
                                                    sat_add(sc_reg, tlen_reg), 8'h00);
                            rn = rn + 4'd1;
                            mode_next = sbl_pkg::MODE_NORMAL;
                        end else if (x == sbl_pkg::CH_BSLASH) begin
                            mode_next = sbl_pkg::MODE_ESC;
                        end else begin
                            tlen_next = sat_add(tlen_reg, PB'(1));
                            res[rn[2:0]] = pack_res(sbl_pkg::KIND_TEXT, line_reg, cc,
                                                    sat_add(cc, PB'(1)), x);
                            rn = rn + 4'd1;
                        end
                    end
                    sbl_pkg::MODE_ESC: begin
                        tlen_next = sat_add(tlen_reg, PB'(1));
                        res[rn[2:0]] = pack_res(sbl_pkg::KIND_TEXT, line_reg, cc,
                                                sat_add(cc, PB'(1)), unescape(x));
                        rn = rn + 4'd1;
                        mode_next = sbl_pkg::MODE_STR;
                    end
                    sbl_pkg::MODE_LINEC: begin
                        if (x == sbl_pkg::CH_NL) mode_next = sbl_pkg::MODE_NORMAL;
                    end
                    sbl_pkg::MODE_BLOCK, sbl_pkg::MODE_STAR: begin
                        if (mode_reg == sbl_pkg::MODE_STAR && x == sbl_pkg::CH_SLASH)
                            mode_next = sbl_pkg::MODE_NORMAL;
                        else if (x == sbl_pkg::CH_STAR)
                            mode_next = sbl_pkg::MODE_STAR;
                        else
                            mode_next = sbl_pkg::MODE_BLOCK;
                    end
                    default: begin
                        mode_next = sbl_pkg::MODE_NORMAL;
                        walk_run  = 1'b1;
                    end
                endcase
            end else if (mode_reg == sbl_pkg::MODE_NORMAL) begin
                walk_run = 1'b1;
            end

            // punctuator walk; at source end nothing is held back
            if (walk_run) begin
                hc_next = 2'd0;
                for (int k = 0; k < 4; k++) begin
                    if (go && i < m && !halted_next) begin
                        c   = wb[i[1:0]];
                        cci = sat_add(col0, PB'(i));
                        if (!pinfo[i[1:0]].start) begin
                            if (is_ws(c)) begin
                                go = 1'b1;
                            end else if (is_digit(c)) begin
                                mode_next = sbl_pkg::MODE_INT;
                                sl_next   = line_reg;
                                sc_next   = cci;
                                tlen_next = PB'(1);
                            end else if (is_id_start(c)) begin
                                mode_next = sbl_pkg::MODE_IDENT;
                                sl_next   = line_reg;
                                sc_next   = cci;
                                tlen_next = PB'(1);
                                res[rn[2:0]] = pack_res(sbl_pkg::KIND_TEXT, line_reg, cci,
                                                        sat_add(cci, PB'(1)), c);
                                rn = rn + 4'd1;
                            end else if (c == sbl_pkg::CH_DQUOTE
                                         || c == sbl_pkg::CH_SQUOTE) begin
                                mode_next  = sbl_pkg::MODE_STR;
                                sl_next    = line_reg;
                                sc_next    = cci;
                                tlen_next  = '0;
                                quote_next = c;
                            end else begin
                                res[rn[2:0]] = pack_res(sbl_pkg::KIND_ERROR, line_reg, cci,
                                                        sat_add(cci, PB'(1)), 8'h00);
                                rn = rn + 4'd1;
                                halted_next = 1'b1;
                            end
                            i = i + 3'd1;
                        end else if (pinfo[i[1:0]].cmt) begin
                            mode_next = pinfo[i[1:0]].cmt_line ? sbl_pkg::MODE_LINEC
                                                               : sbl_pkg::MODE_BLOCK;
                            sl_next   = line_reg;
                            sc_next   = cci;
                            tlen_next = '0;
                            go        = 1'b0;
                        end else if (!eos_eff && pinfo[i[1:0]].rem <= 3'd3
                                     && pinfo[i[1:0]].prefix) begin
                            tmp          = wcat << {i, 3'b000};
                            held_next[0] = tmp[31:24];
                            held_next[1] = tmp[23:16];
                            held_next[2] = tmp[15:8];
                            hc_next      = pinfo[i[1:0]].rem[1:0];
                            sl_next      = line_reg;
                            sc_next      = cci;
                            go           = 1'b0;
                        end else begin
                            res[rn[2:0]] = pack_res(pinfo[i[1:0]].idx, line_reg, cci,
                                sat_add(cci, PB'(pinfo[i[1:0]].len)), 8'h00);
                            rn = rn + 4'd1;
                            i  = i + pinfo[i[1:0]].len;
                        end
                    end
                end
            end

            if (x != 8'h00) begin
                if (x == sbl_pkg::CH_NL && mode_reg != sbl_pkg::MODE_STR
                    && mode_reg != sbl_pkg::MODE_ESC) begin
                    line_next = sat_add(line_reg, PB'(1));
                    col_next  = '0;
                end else begin
                    col_next = cc;
                end
            end

            // source end: close the token, then end word, or an error
            if (eos_eff && !halted_next) begin
                case (mode_next)
                    sbl_pkg::MODE_IDENT: begin
                        res[rn[2:0]] = pack_res(sbl_pkg::KIND_IDENT, sl_next, sc_next,
                                                sat_add(sc_next, tlen_next), 8'h00);
                        rn = rn + 4'd1;
                    end
                    sbl_pkg::MODE_INT, sbl_pkg::MODE_FRAC: begin
                        res[rn[2:0]] = pack_res(sbl_pkg::KIND_NUMBER, sl_next, sc_next,
                            sat_add(sc_next, (tlen_next != '0) ? tlen_next - PB'(1) : '0),
                            8'h00);
                        rn = rn + 4'd1;
                    end
                    sbl_pkg::MODE_STR, sbl_pkg::MODE_ESC,
                    sbl_pkg::MODE_BLOCK, sbl_pkg::MODE_STAR: begin
                        res[rn[2:0]] = pack_res(sbl_pkg::KIND_ERROR, sl_next, sc_next,
                                                sat_add(sc_next, PB'(1)), 8'h00);
                        rn = rn + 4'd1;
                        halted_next = 1'b1;
                    end
                    default: begin
                        go = 1'b0;
                    end
                endcase
                if (!halted_next) begin
                    res[rn[2:0]] = pack_res(sbl_pkg::KIND_END, line_next,
                                            sat_add(col_next, PB'(1)),
                                            sat_add(col_next, PB'(1)), 8'h00);
                    rn = rn + 4'd1;
                    mode_next  = sbl_pkg::MODE_NORMAL;
                    held_next  = '{8'h00, 8'h00, 8'h00};
                    hc_next    = 2'd0;
                    line_next  = PB'(1);
                    col_next   = '0;
                    sl_next    = '0;
                    sc_next    = '0;
                    tlen_next  = '0;
                    quote_next = 8'h00;
                end
            end

            // too many words for one byte: keep three, then an error
            if (rn > 4'd4) begin
                res[3] = pack_res(sbl_pkg::KIND_ERROR, line_reg, bc,
                                  sat_add(bc, PB'(1)), 8'h00);
                rn = 4'd4;
                halted_next = 1'b1;
            end
        end
        res_n = rn;
    end

    assign push      = accept && res_n != 4'd0;
    assign push_data = {res[3], res[2], res[1], res[0], res_n[2:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= sbl_pkg::MODE_NORMAL;
            held_reg   <= '{8'h00, 8'h00, 8'h00};
            hc_reg     <= 2'd0;
            line_reg   <= PB'(1);
            col_reg    <= '0;
            sl_reg     <= '0;
            sc_reg     <= '0;
            tlen_reg   <= '0;
            quote_reg  <= 8'h00;
            halted_reg <= 1'b0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            hc_reg     <= hc_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            sl_reg     <= sl_next;
            sc_reg     <= sc_next;
            tlen_reg   <= tlen_next;
            quote_reg  <= quote_next;
            halted_reg <= halted_next;
        end
    end

    `SBL_ASSERT_IMP(a_halted_silent, halted_reg, !push, "halted lexer produced words")
    `SBL_ASSERT_IMP(a_bundle_count, push, res_n <= 4'd4, "bad bundle count")

endmodule

// ===== sv/sbl_queue.sv =====
// ---------------------------------------------------------------------------
// sbl_queue
// Small bundle FIFO between the classifier and the word serializer.
// ---------------------------------------------------------------------------
module sbl_queue #(
    parameter int DATA_W = sbl_pkg::CNT_BITS + sbl_pkg::SLOTS
                         * (sbl_pkg::FIXED_RES_BITS + 3 * sbl_pkg::POSITION_BITS_DEF)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output sbl_pkg::qstat_t   qstat
);
    `include "script_byte_lexer_assert.svh"

    localparam int DEPTH = sbl_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [AW:0]       cnt_reg;

    assign qstat.full  = cnt_reg == (AW + 1)'(DEPTH);
    assign qstat.empty = cnt_reg == '0;
    assign head_data   = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + AW'(1);
            if (pop)  rd_reg <= rd_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW + 1)'(push) - (AW + 1)'(pop);
        end
    end

    `SBL_ASSERT_IMP(a_no_overflow, push, !qstat.full || pop, "push into full queue")
    `SBL_ASSERT_IMP(a_no_underflow, pop, !qstat.empty, "pop from empty queue")

endmodule

// ===== sv/sbl_back.sv =====
// ---------------------------------------------------------------------------
// sbl_back
// Word serializer: head bundle to m_ regs, one word per cycle unless stalled.
// ---------------------------------------------------------------------------
module sbl_back #(
    parameter int POSITION_BITS = sbl_pkg::POSITION_BITS_DEF,
    localparam int RW = sbl_pkg::FIXED_RES_BITS + 3 * POSITION_BITS,
    localparam int BW = sbl_pkg::CNT_BITS + sbl_pkg::SLOTS * RW,
    localparam int DW = ((RW + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [BW-1:0]   head_data,
    input  sbl_pkg::qstat_t qstat,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [DW-1:0]   m_tdata,
    output logic            m_tlast
);
    `include "script_byte_lexer_assert.svh"

    logic [1:0]    sel_reg;
    logic          ovalid_reg;
    logic [RW-1:0] odata_reg;
    logic          olast_reg;

    logic          load;
    logic          is_last;
    logic [2:0]    cnt;
    logic [RW-1:0] slot;

    assign cnt     = head_data[sbl_pkg::CNT_BITS-1:0];
    assign slot    = head_data[sbl_pkg::CNT_BITS + sel_reg * RW +: RW];
    assign load    = !qstat.empty && (!ovalid_reg || m_tready);
    assign is_last = ({1'b0, sel_reg} + 3'd1) == cnt;
    assign pop     = load && is_last;

    always_ff @(posedge aclk) begin
        if (load) begin
            odata_reg <= slot;
            olast_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end else begin
            if (load) begin
                ovalid_reg <= 1'b1;
                sel_reg    <= is_last ? 2'd0 : sel_reg + 2'd1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = DW'(odata_reg);
    assign m_tlast  = olast_reg;

    `SBL_ASSERT_IMP(a_head_held, sel_reg != 2'd0, !qstat.empty, "bundle left queue mid-way")

endmodule

// ===== sv/script_byte_lexer.sv =====
// ---------------------------------------------------------------------------
// script_byte_lexer
// Streaming tokenizer for a script language, one source byte per word.
// ---------------------------------------------------------------------------
// Feed source bytes on s_ (tdata = byte, tlast = last byte of the source; a
// zero byte also ends it). The block skips whitespace and comments and gives
// on m_ one word per text character (identifier and string characters, escapes
// decoded) followed by the token word: identifier, number, string, one of 51
// punctuators (longest match), and an end word at source end, after which it
// starts over at line 1. A bad byte, an unterminated string or block comment or
// more than four words from one byte give an error word; the block then swallows
// input without output until reset. Each byte is classified in the cycle it is
// accepted and yields 0 to 4 words; those go as one bundle into a 4-entry queue,
// and the serializer sends one word per cycle while m_tready is high. A byte is
// taken every cycle while the queue has room, so the sustained rate is one byte
// per cycle when bytes average at most one word, otherwise set by the output.
module script_byte_lexer #(
    parameter int POSITION_BITS = sbl_pkg::POSITION_BITS_DEF,
    localparam int RW = sbl_pkg::FIXED_RES_BITS + 3 * POSITION_BITS,
    localparam int DW = ((RW + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    // source bytes
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,    // [7:0] ch
    input  logic          s_tlast,    // end_of_source
    // words out
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [DW-1:0] m_tdata,    // kind, line, column, end_column, text_value, zero pad
    output logic          m_tlast     // last word caused by this byte
);

    localparam int BW = sbl_pkg::CNT_BITS + sbl_pkg::SLOTS * RW;

    logic            push;
    logic [BW-1:0]   push_data;
    logic            pop;
    logic [BW-1:0]   head_data;
    sbl_pkg::qstat_t qstat;

    // classifier: holds all lexer state, builds a bundle per byte
    sbl_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // bundle queue: lets classifier and output stall independently
    sbl_queue #(.DATA_W(BW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .qstat     (qstat)
    );

    // serializer with registered output
    sbl_back #(.POSITION_BITS(POSITION_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_data (head_data),
        .qstat     (qstat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== tb/sbl_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbl_checker
// Watches both channels of the lexer, predicts its words and compares them.
// ---------------------------------------------------------------------------
module sbl_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          words_pending
);

    localparam int unsigned POS_MAX = 65535;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] endc;
        logic [7:0]  txt;
        logic        tail;
    } lex_word_t;

    lex_word_t   token_words[$];   // expected words, oldest first
    lex_word_t   byte_words[$];    // words caused by the current byte

    sbl_pkg::mode_t mode;
    logic [31:0] held_win;         // held punctuator bytes, first in the low byte
    int unsigned held_n;
    int unsigned cur_line, cur_col, start_line, start_col, tok_len;
    logic [7:0]  quote;
    bit          halted;

    assign words_pending = token_words.size();

    function automatic int unsigned sat(input int unsigned a, input int unsigned b);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        return (s > POS_MAX) ? POS_MAX : int'(s);
    endfunction

    function automatic void put_word(input logic [5:0] k, input int unsigned ln,
                                     input int unsigned c, input int unsigned e,
                                     input logic [7:0] t);
        lex_word_t w;
        if (byte_words.size() >= 8) return;
        w.kind = k; w.line = ln[15:0]; w.col = c[15:0]; w.endc = e[15:0];
        w.txt = t; w.tail = 1'b0;
        byte_words.push_back(w);
    endfunction

    function automatic void go_error(input int unsigned ln, input int unsigned c);
        put_word(sbl_pkg::KIND_ERROR, ln, c, sat(c, 1), 8'h00);
        halted = 1'b1;
    endfunction

    function automatic void clear_lexer();
        mode = sbl_pkg::MODE_NORMAL; held_win = '0; held_n = 0;
        cur_line = 1; cur_col = 0; start_line = 0; start_col = 0;
        tok_len = 0; quote = 8'h00; halted = 1'b0;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_id_start(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               c == sbl_pkg::CH_DOLLAR || c == sbl_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] p_byte(input int e, input int k);
        return sbl_pkg::PUNCT_STR[e][31-8*k -: 8];
    endfunction

    function automatic int unsigned p_len(input int e);
        int unsigned n;
        n = 0;
        for (int k = 0; k < 4; k++)
            if (p_byte(e, k) != 8'h00) n++;
        return n;
    endfunction

    // first l bytes of the window equal entry e
    function automatic bit entry_hits(input int e, input logic [31:0] w, input int unsigned l);
        for (int k = 0; k < int'(l); k++)
            if (p_byte(e, k) != w[8*k +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit is_pstart(input logic [7:0] c);
        for (int e = 0; e < sbl_pkg::PUNCT_COUNT; e++)
            if (p_byte(e, 0) == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit is_prefix(input logic [31:0] w, input int unsigned m);
        for (int e = 0; e < sbl_pkg::PUNCT_COUNT; e++)
            if (p_len(e) > m && entry_hits(e, w, m)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int unsigned longest(input logic [31:0] w, input int unsigned m,
                                            output int idx);
        int unsigned best, l;
        best = 0; idx = 0;
        for (int e = 0; e < sbl_pkg::PUNCT_COUNT; e++) begin
            l = p_len(e);
            if (l <= m && l > best && entry_hits(e, w, l)) begin
                best = l; idx = e;
            end
        end
        return best;
    endfunction

    function automatic void start_tok(input sbl_pkg::mode_t md, input int unsigned cc,
                                      input int unsigned len);
        mode = md; start_line = cur_line; start_col = cc; tok_len = len;
    endfunction

    // byte that starts no punctuator
    function automatic void dispatch(input logic [7:0] c, input int unsigned cc);
        if (c == sbl_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13)) return;
        if (is_digit(c)) begin
            start_tok(sbl_pkg::MODE_INT, cc, 1);
        end else if (is_id_start(c)) begin
            start_tok(sbl_pkg::MODE_IDENT, cc, 1);
            put_word(sbl_pkg::KIND_TEXT, cur_line, cc, sat(cc, 1), c);
        end else if (c == sbl_pkg::CH_DQUOTE || c == sbl_pkg::CH_SQUOTE) begin
            start_tok(sbl_pkg::MODE_STR, cc, 0);
            quote = c;
        end else begin
            go_error(cur_line, cc);
        end
    endfunction

    // longest-match scan over up to four bytes; may hold a proper prefix
    function automatic void lex_window(input logic [31:0] win, input int unsigned m,
                                       input int unsigned col0, input bit flush);
        int unsigned i, rem, len, cc;
        int          idx;
        logic [31:0] sub;
        logic [7:0]  c;
        i = 0;
        while (i < m && !halted) begin
            sub = win >> (8 * i);
            c   = sub[7:0];
            cc  = sat(col0, i);
            rem = m - i;
            if (!is_pstart(c)) begin
                dispatch(c, cc);
                i++;
                continue;
            end
            if (c == sbl_pkg::CH_SLASH && rem >= 2
                && (sub[15:8] == sbl_pkg::CH_SLASH || sub[15:8] == sbl_pkg::CH_STAR)) begin
                start_tok(sub[15:8] == sbl_pkg::CH_SLASH ? sbl_pkg::MODE_LINEC
                                                         : sbl_pkg::MODE_BLOCK, cc, 0);
                return;
            end
            if (!flush && rem <= 3 && is_prefix(sub, rem)) begin
                held_win = sub; held_n = rem;
                start_line = cur_line; start_col = cc;
                return;
            end
            len = longest(sub, rem, idx);
            if (len == 0) len = 1;
            put_word(6'(idx), cur_line, cc, sat(cc, len), 8'h00);
            i += len;
        end
    endfunction

    function automatic void punct_feed(input logic [7:0] x, input int unsigned cc);
        logic [31:0] w;
        int unsigned m, col0;
        m    = held_n;
        col0 = (m != 0) ? start_col : cc;
        w    = held_win;
        w[8*m +: 8] = x;
        held_n = 0;
        lex_window(w, m + 1, col0, 1'b0);
    endfunction

    function automatic void finish_tok();
        if (mode == sbl_pkg::MODE_IDENT)
            put_word(sbl_pkg::KIND_IDENT, start_line, start_col,
                     sat(start_col, tok_len), 8'h00);
        else  // numbers span length minus one
            put_word(sbl_pkg::KIND_NUMBER, start_line, start_col,
                     sat(start_col, tok_len != 0 ? tok_len - 1 : 0), 8'h00);
        mode = sbl_pkg::MODE_NORMAL;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            "n":     return 8'd10;
            "r":     return 8'd13;
            "t":     return 8'd9;
            "b":     return 8'd8;
            "f":     return 8'd12;
            "v":     return 8'd11;
            "0":     return 8'd0;
            default: return c;
        endcase
    endfunction

    function automatic void lex_byte(input logic [7:0] x);
        int unsigned cc;
        bit in_str;
        in_str  = (mode == sbl_pkg::MODE_STR || mode == sbl_pkg::MODE_ESC);
        cur_col = sat(cur_col, 1);
        cc      = cur_col;
        case (mode)
            sbl_pkg::MODE_IDENT: begin
                if (is_id_start(x) || is_digit(x)) begin
                    tok_len = sat(tok_len, 1);
                    put_word(sbl_pkg::KIND_TEXT, cur_line, cc, sat(cc, 1), x);
                end else begin
                    finish_tok();
                    punct_feed(x, cc);
                end
            end
            sbl_pkg::MODE_INT, sbl_pkg::MODE_FRAC: begin
                if (is_digit(x)) begin
                    tok_len = sat(tok_len, 1);
                end else if (x == sbl_pkg::CH_DOT && mode == sbl_pkg::MODE_INT) begin
                    tok_len = sat(tok_len, 1);
                    mode = sbl_pkg::MODE_FRAC;
                end else begin
                    finish_tok();
                    punct_feed(x, cc);
                end
            end
            sbl_pkg::MODE_STR: begin
                if (x == quote) begin
                    put_word(sbl_pkg::KIND_STRING, start_line, start_col,
                             sat(start_col, tok_len), 8'h00);
                    mode = sbl_pkg::MODE_NORMAL;
                end else if (x == sbl_pkg::CH_BSLASH) begin
                    mode = sbl_pkg::MODE_ESC;
                end else begin
                    tok_len = sat(tok_len, 1);
                    put_word(sbl_pkg::KIND_TEXT, cur_line, cc, sat(cc, 1), x);
                end
            end
            sbl_pkg::MODE_ESC: begin
                tok_len = sat(tok_len, 1);
                put_word(sbl_pkg::KIND_TEXT, cur_line, cc, sat(cc, 1), unescape(x));
                mode = sbl_pkg::MODE_STR;
            end
            sbl_pkg::MODE_LINEC: begin
                if (x == sbl_pkg::CH_NL) mode = sbl_pkg::MODE_NORMAL;
            end
            sbl_pkg::MODE_BLOCK, sbl_pkg::MODE_STAR: begin
                if (mode == sbl_pkg::MODE_STAR && x == sbl_pkg::CH_SLASH)
                    mode = sbl_pkg::MODE_NORMAL;
                else
                    mode = (x == sbl_pkg::CH_STAR) ? sbl_pkg::MODE_STAR
                                                   : sbl_pkg::MODE_BLOCK;
            end
            default: begin
                mode = sbl_pkg::MODE_NORMAL;
                punct_feed(x, cc);
            end
        endcase
        if (x == sbl_pkg::CH_NL && !in_str) begin
            cur_line = sat(cur_line, 1);
            cur_col  = 0;
        end
    endfunction

    function automatic void end_source();
        int unsigned c, n;
        if (halted) return;
        case (mode)
            sbl_pkg::MODE_IDENT, sbl_pkg::MODE_INT, sbl_pkg::MODE_FRAC: finish_tok();
            sbl_pkg::MODE_STR, sbl_pkg::MODE_ESC,
            sbl_pkg::MODE_BLOCK, sbl_pkg::MODE_STAR: begin
                go_error(start_line, start_col);   // unterminated, reported at its start
                return;
            end
            sbl_pkg::MODE_LINEC: ;
            default: begin
                if (held_n != 0) begin
                    n = held_n;
                    held_n = 0;
                    lex_window(held_win, n, start_col, 1'b1);
                end
            end
        endcase
        c = sat(cur_col, 1);
        put_word(sbl_pkg::KIND_END, cur_line, c, c, 8'h00);
        clear_lexer();
    endfunction

    function automatic void predict_byte(input logic [7:0] x, input logic eos);
        int unsigned bl, bc;
        lex_word_t   w;
        bl = cur_line;
        bc = sat(cur_col, 1);
        byte_words.delete();
        if (halted) return;
        if (x != 8'h00) lex_byte(x);
        if (x == 8'h00 || eos) end_source();
        // more than four words: keep three, then an error at this byte
        if (byte_words.size() > 4) begin
            while (byte_words.size() > 3) void'(byte_words.pop_back());
            put_word(sbl_pkg::KIND_ERROR, bl, bc, sat(bc, 1), 8'h00);
            halted = 1'b1;
        end
        foreach (byte_words[k]) begin
            w = byte_words[k];
            w.tail = (k == byte_words.size() - 1);
            token_words.push_back(w);
        end
    endfunction

    always @(posedge aclk) begin
        lex_word_t got, want;
        if (!aresetn) begin
            clear_lexer();
            token_words.delete();
            fail_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind = m_tdata[5:0];   got.line = m_tdata[21:6];
                got.col  = m_tdata[37:22]; got.endc = m_tdata[53:38];
                got.txt  = m_tdata[61:54]; got.tail = m_tlast;
                if (token_words.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected word: kind %0d line %0d col %0d", got.kind,
                                 got.line, got.col);
                    fail_count <= fail_count + 1;
                end else begin
                    want = token_words.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"word mismatch: exp k%0d l%0d c%0d e%0d t%0d last%0d,",
                                      " got k%0d l%0d c%0d e%0d t%0d last%0d"},
                                     want.kind, want.line, want.col, want.endc, want.txt,
                                     want.tail, got.kind, got.line, got.col, got.endc,
                                     got.txt, got.tail);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Lexer test: directed source, random well-formed sources, one fatal ending.
// ---------------------------------------------------------------------------
// Builds a byte stream of whole sources made of random tokens (names,
// numbers, strings with escapes and high bytes, punctuators, comments,
// blank space) each closed by a zero byte or a tlast byte. Since an error
// halts the lexer until reset, the stream ends with exactly one error case
// picked at random, followed by a few bytes that must produce nothing.
// The checker predicts and compares every word.
module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          words_pending;

    logic [8:0]  src_q[$];     // {tlast, byte}
    bit          steady = 1'b0; // no idling on either side while set

    always #5 aclk = ~aclk;

    script_byte_lexer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    sbl_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .words_pending(words_pending)
    );

    // receiver stalls about 15 percent of cycles outside the steady window
    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(99) >= 15);

    task automatic put(input logic [7:0] b, input logic l = 1'b0);
        src_q.push_back({l, b});
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    function automatic logic [7:0] id_char(input bit first);
        int r;
        r = first ? $urandom_range(0, 53) : $urandom_range(0, 63);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return sbl_pkg::CH_DOLLAR;
        if (r == 53) return sbl_pkg::CH_UNDER;
        return 8'("0" + r - 54);
    endfunction

    task automatic put_token();
        logic [7:0] q, b;
        int e;
        // keep a trailing slash from turning the next token into a comment
        if (src_q.size() != 0 && src_q[$][7:0] == sbl_pkg::CH_SLASH) put(sbl_pkg::CH_SPACE);
        case ($urandom_range(0, 9))
            0, 1: begin
                put(id_char(1));
                repeat ($urandom_range(0, 5)) put(id_char(0));
            end
            2: begin
                repeat ($urandom_range(1, 4)) put(8'("0" + $urandom_range(0, 9)));
                if ($urandom_range(1)) begin
                    put(sbl_pkg::CH_DOT);
                    repeat ($urandom_range(0, 3)) put(8'("0" + $urandom_range(0, 9)));
                end
            end
            3: begin
                q = $urandom_range(1) ? sbl_pkg::CH_DQUOTE : sbl_pkg::CH_SQUOTE;
                put(q);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(4) == 0) begin
                        put(sbl_pkg::CH_BSLASH);
                        case ($urandom_range(0, 7))
                            0: put("n"); 1: put("r"); 2: put("t"); 3: put("b");
                            4: put("f"); 5: put("v"); 6: put("0");
                            default: put(8'($urandom_range(1, 255)));
                        endcase
                    end else begin
                        do b = 8'($urandom_range(1, 255));
                        while (b == q || b == sbl_pkg::CH_BSLASH);
                        put(b);
                    end
                end
                put(q);
            end
            4, 5, 6: begin
                e = $urandom_range(0, sbl_pkg::PUNCT_COUNT - 1);
                for (int k = 0; k < 4; k++)
                    if (sbl_pkg::PUNCT_STR[e][31-8*k -: 8] != 8'h00)
                        put(sbl_pkg::PUNCT_STR[e][31-8*k -: 8]);
            end
            7: begin
                case ($urandom_range(0, 5))
                    0: put(sbl_pkg::CH_SPACE); 1: put(8'd9); 2: put(sbl_pkg::CH_NL);
                    3: put(8'd13); 4: put(8'd11); default: put(8'd12);
                endcase
            end
            8: begin
                put_str("//");
                repeat ($urandom_range(0, 5)) begin
                    do b = 8'($urandom_range(1, 255)); while (b == sbl_pkg::CH_NL);
                    put(b);
                end
                put(sbl_pkg::CH_NL);
            end
            default: begin
                put_str("/*");
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 2))
                        0: put(sbl_pkg::CH_SPACE); 1: put(sbl_pkg::CH_NL);
                        default: put(8'("a" + $urandom_range(0, 25)));
                    endcase
                end
                put_str("*/");
            end
        endcase
    endtask

    // close a source: zero byte (tlast either way) or a tlast byte
    task automatic end_src();
        case ($urandom_range(0, 4))
            0: put(8'h00, 1'($urandom_range(1)));
            1: put(sbl_pkg::CH_SPACE, 1'b1);
            2: put(sbl_pkg::CH_NL, 1'b1);
            3: put(";", 1'b1);
            default: put("z", 1'b1);
        endcase
    endtask

    task automatic send_byte(input logic [8:0] w);
        bit rdy;
        while (!steady && $urandom_range(99) < 15) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = w[7:0];
        s_tlast  = w[8];
        do begin
            #1 rdy = s_tready;
            @(negedge aclk);
        end while (!rdy);
    endtask

    initial begin
        // directed: longest matches, held prefixes, escapes, high bytes, comments
        put_str(">>>=>>>...<<=>>=**====!==!=!a$_9 'x\\q\\n\\0' \"");
        put(8'hFF); put(8'h80);
        put_str("\" 3.25 7. //c\n/* ** */..");
        put(8'h00, 1'b1);
        put_str("ab<");
        put(sbl_pkg::CH_SPACE, 1'b1);
        while (src_q.size() < 450) begin
            repeat ($urandom_range(3, 15)) put_token();
            end_src();
        end
        // one fatal ending, since the lexer then halts until reset
        case ($urandom_range(0, 3))
            0: begin
                put_str("a ");
                put($urandom_range(1) ? 8'($urandom_range(128, 255)) : "#");
            end
            1: begin put_str("x \"ab"); put(8'h00); end
            2: begin put_str("/*ab"); put("c", 1'b1); end
            default: begin put_str(".."); put("x", 1'b1); end   // five words in one step
        endcase
        repeat (5) put(8'($urandom_range(0, 255)), 1'($urandom_range(1)));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        foreach (src_q[i]) begin
            steady = (i >= 150 && i < 300);
            send_byte(src_q[i]);
        end
        s_tvalid = 1'b0;
        steady = 1'b0;
        while (words_pending != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("[script_byte_lexer] OK");
        else
            $display("[script_byte_lexer] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[script_byte_lexer] ERROR");
        $finish;
    end

endmodule
